// ===== hdl/kevb_pkg.sv =====
// ----------------------------------------------------------------------------
// kevb_pkg: shared types and constants
// Key codes, escape bytes, UTF-16 ranges, byte buffer types and the UTF-8
// encoder used by the key event byte generator.
// ----------------------------------------------------------------------------
package kevb_pkg;

  localparam int SeqBytes = 4;                      // longest run of one sequence
  localparam int IdxW     = $clog2(SeqBytes);
  localparam int LenW     = $clog2(SeqBytes + 1);
  localparam int RepW     = 5;
  localparam logic [RepW-1:0] RepCap = 5'd16;
  localparam logic [RepW-1:0] RepLimitRst = 5'd16;

  localparam logic [15:0] KeyEnd   = 16'h0023;
  localparam logic [15:0] KeyHome  = 16'h0024;
  localparam logic [15:0] KeyLeft  = 16'h0025;
  localparam logic [15:0] KeyUp    = 16'h0026;
  localparam logic [15:0] KeyRight = 16'h0027;
  localparam logic [15:0] KeyDown  = 16'h0028;
  localparam logic [15:0] KeyDel   = 16'h002E;

  localparam logic [7:0] ChEsc   = 8'h1B;
  localparam logic [7:0] ChBrack = 8'h5B;
  localparam logic [7:0] ChA     = 8'h41;
  localparam logic [7:0] ChB     = 8'h42;
  localparam logic [7:0] ChC     = 8'h43;
  localparam logic [7:0] ChD     = 8'h44;
  localparam logic [7:0] ChH     = 8'h48;
  localparam logic [7:0] ChF     = 8'h46;
  localparam logic [7:0] Ch3     = 8'h33;
  localparam logic [7:0] ChTilde = 8'h7E;

  localparam logic [15:0] HiSurLo = 16'hD800;
  localparam logic [15:0] HiSurHi = 16'hDBFF;
  localparam logic [15:0] LoSurLo = 16'hDC00;
  localparam logic [15:0] LoSurHi = 16'hDFFF;

  typedef logic [SeqBytes-1:0][7:0] byte_arr_t;

  typedef struct packed {
    byte_arr_t        bytes;
    logic [LenW-1:0]  len;
  } seq_t;

  typedef struct packed {
    logic load;   // request accepted: latch its byte run
    logic step;   // move the next byte into the output register
  } dp_cmd_t;

  typedef struct packed {
    logic has_run;   // the offered request yields at least one byte
    logic run_end;   // the byte at the head is the final one
    logic out_free;  // output register can take a byte this cycle
  } dp_sts_t;

  // UTF-8 encoding of a 21-bit code point
  function automatic seq_t utf8_enc(input logic [20:0] cp);
    seq_t s;
    s.bytes = '0;
    if (cp < 21'h80) begin
      s.bytes[0] = cp[7:0];
      s.len      = LenW'(1);
    end else if (cp < 21'h800) begin
      s.bytes[0] = {3'b110, cp[10:6]};
      s.bytes[1] = {2'b10, cp[5:0]};
      s.len      = LenW'(2);
    end else if (cp < 21'h10000) begin
      s.bytes[0] = {4'b1110, cp[15:12]};
      s.bytes[1] = {2'b10, cp[11:6]};
      s.bytes[2] = {2'b10, cp[5:0]};
      s.len      = LenW'(3);
    end else begin
      s.bytes[0] = {5'b11110, cp[20:18]};
      s.bytes[1] = {2'b10, cp[17:12]};
      s.bytes[2] = {2'b10, cp[11:6]};
      s.bytes[3] = {2'b10, cp[5:0]};
      s.len      = LenW'(4);
    end
    return s;
  endfunction

endpackage

// ===== hdl/kevb_in_if.sv =====
// ----------------------------------------------------------------------------
// kevb_in_if: key event request channel
// Valid/ready channel carrying one keyboard event.
// ----------------------------------------------------------------------------
interface kevb_in_if;
  logic        valid;
  logic        ready;
  logic        key_down;
  logic [15:0] key_code;
  logic [15:0] char_unit;
  logic [15:0] rpt_cnt;

  modport source (output valid, key_down, key_code, char_unit, rpt_cnt,
                  input ready);
  modport sink   (input valid, key_down, key_code, char_unit, rpt_cnt,
                  output ready);
endinterface

// ===== hdl/kevb_out_if.sv =====
// ----------------------------------------------------------------------------
// kevb_out_if: output byte channel
// Valid/ready channel carrying one byte and its end-of-run flag.
// ----------------------------------------------------------------------------
interface kevb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, out_byte, last, input ready);
  modport sink   (input valid, out_byte, last, output ready);
endinterface

// ===== hdl/key_event_to_vt_utf8_bytes_core.sv =====
// ----------------------------------------------------------------------------
// key_event_to_vt_utf8_bytes_core: keyboard event to VT/UTF-8 byte stream
// Top level joining the sequencing controller and the byte run datapath.
// ----------------------------------------------------------------------------
// One keyboard event request comes in on evt_i and leaves as a run of bytes
// on byte_o, one byte per cycle unless stalled, its final byte marked by last.
// Cursor and editing keys give VT sequences (ESC [ A/B/C/D/H/F, ESC [ 3 ~);
// other keys give their UTF-16 unit as UTF-8, with a high surrogate held
// until a low surrogate completes the pair. Releases, lone low surrogates,
// a bare high surrogate and a zero unit give no bytes. The run repeats as
// often as the request's rpt_cnt field asks (0 means once), capped by the
// repeat limit register limit_q
// written through cfg_we_i/cfg_wdata_i (0 acts as 1, above 16 as 16; reset
// 16). A request is taken while idle; a request that gives bytes then
// occupies the block while the single output byte register drains the
// buffered sequence, one byte a cycle unless byte_o stalls, len*reps bytes
// in all (len 1..4, reps 1..16, so up to 64). The next request is taken as
// soon as the final byte sits in the output register; requests giving no
// bytes leave the block idle.
// ----------------------------------------------------------------------------
module key_event_to_vt_utf8_bytes_core import kevb_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [RepW-1:0] cfg_wdata_i,
  kevb_in_if.sink         evt_i,
  kevb_out_if.source      byte_o
);

  dp_cmd_t cmd;   // controller to datapath
  dp_sts_t sts;   // datapath to controller

  kevb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (evt_i.valid),
    .in_ready_o (evt_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath decodes the offered request combinationally; the controller
  // only raises load on an accepted request
  kevb_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .key_down_i     (evt_i.key_down),
    .key_code_i     (evt_i.key_code),
    .char_unit_i    (evt_i.char_unit),
    .rpt_cnt_i      (evt_i.rpt_cnt),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_ready_i    (byte_o.ready),
    .out_valid_o    (byte_o.valid),
    .out_byte_o     (byte_o.out_byte),
    .out_last_o     (byte_o.last)
  );

endmodule

// ===== hdl/kevb_ctrl.sv =====
// ----------------------------------------------------------------------------
// kevb_ctrl: sequencing controller
// Accepts a request when idle and steps its byte run into the output register.
// ----------------------------------------------------------------------------
module kevb_ctrl import kevb_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
        if (in_valid_i && sts_i.has_run) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd_o.step = sts_i.out_free;
        if (sts_i.out_free && sts_i.run_end) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hdl/kevb_dp.sv =====
// ----------------------------------------------------------------------------
// kevb_dp: byte run datapath
// Key decode, surrogate hold, repeat limit, byte buffer, counters and the
// output register.
// ----------------------------------------------------------------------------
module kevb_dp import kevb_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [RepW-1:0] cfg_wdata_i,
  input  logic            key_down_i,
  input  logic [15:0]     key_code_i,
  input  logic [15:0]     char_unit_i,
  input  logic [15:0]     rpt_cnt_i,
  input  dp_cmd_t         cmd_i,
  output dp_sts_t         sts_o,
  input  logic            out_ready_i,
  output logic            out_valid_o,
  output logic [7:0]      out_byte_o,
  output logic            out_last_o
);

  logic [RepW-1:0] limit_q;
  logic [15:0]     held_q, held_d;
  byte_arr_t       buf_q;
  logic [LenW-1:0] len_q;
  logic [IdxW-1:0] idx_q;
  logic [RepW-1:0] rep_left_q;
  logic            out_valid_q;
  logic [7:0]      out_byte_q;
  logic            out_last_q;

  logic            special;
  seq_t            spec_seq, seq;
  logic            is_high, is_low;
  logic [20:0]     pair_cp;
  logic [RepW-1:0] lim_eff, reps;

  // decode of the offered event
  always_comb begin
    special        = 1'b1;
    spec_seq.bytes = '0;
    spec_seq.bytes[0] = ChEsc;
    spec_seq.bytes[1] = ChBrack;
    spec_seq.len   = LenW'(3);
    case (key_code_i)
      KeyUp:    spec_seq.bytes[2] = ChA;
      KeyDown:  spec_seq.bytes[2] = ChB;
      KeyRight: spec_seq.bytes[2] = ChC;
      KeyLeft:  spec_seq.bytes[2] = ChD;
      KeyHome:  spec_seq.bytes[2] = ChH;
      KeyEnd:   spec_seq.bytes[2] = ChF;
      KeyDel: begin
        spec_seq.bytes[2] = Ch3;
        spec_seq.bytes[3] = ChTilde;
        spec_seq.len      = LenW'(4);
      end
      default: special = 1'b0;
    endcase

    is_high = (char_unit_i >= HiSurLo) && (char_unit_i <= HiSurHi);
    is_low  = (char_unit_i >= LoSurLo) && (char_unit_i <= LoSurHi);
    // held unit is zero or a high surrogate; when non-zero its low ten bits are the offset
    pair_cp = {1'b0, held_q[9:0], char_unit_i[9:0]} + 21'h10000;

    if (special) begin
      seq = spec_seq;
    end else if (is_low) begin
      seq = utf8_enc(pair_cp);
    end else begin
      seq = utf8_enc({5'd0, char_unit_i});
    end

    sts_o.has_run = key_down_i &&
                    (special || (is_low && (held_q != '0)) ||
                     (!is_high && !is_low && (char_unit_i != '0)));
    sts_o.run_end  = (LenW'(idx_q) + LenW'(1) == len_q) && (rep_left_q == RepW'(1));
    sts_o.out_free = !out_valid_q || out_ready_i;

    held_d = held_q;
    if (key_down_i && !special) begin
      held_d = is_high ? char_unit_i : '0;
    end

    if (limit_q == '0) begin
      lim_eff = RepW'(1);
    end else if (limit_q > RepCap) begin
      lim_eff = RepCap;
    end else begin
      lim_eff = limit_q;
    end

    if (rpt_cnt_i == '0) begin
      reps = RepW'(1);
    end else if (rpt_cnt_i > {{(16-RepW){1'b0}}, lim_eff}) begin
      reps = lim_eff;
    end else begin
      reps = rpt_cnt_i[RepW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= RepLimitRst;
      held_q      <= '0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      rep_left_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (cmd_i.load) begin
        held_q     <= held_d;
        idx_q      <= '0;
        rep_left_q <= reps;
      end else if (cmd_i.step) begin
        if (LenW'(idx_q) + LenW'(1) == len_q) begin
          idx_q      <= '0;
          rep_left_q <= rep_left_q - RepW'(1);
        end else begin
          idx_q <= idx_q + IdxW'(1);
        end
      end
      if (cmd_i.step) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      buf_q <= seq.bytes;
      len_q <= seq.len;
    end
    if (cmd_i.step) begin
      out_byte_q <= buf_q[idx_q];
      out_last_q <= sts_o.run_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

endmodule

// ===== hdl/kevb_chk.sv =====
// ----------------------------------------------------------------------------
// kevb_chk: port-level checks
// Temporal checks on the top level's channels, bound to the top level.
// ----------------------------------------------------------------------------
module kevb_chk import kevb_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        in_key_down_i,
  input logic [15:0] in_key_code_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [7:0]  out_byte_i,
  input logic        out_last_i
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  // stalled byte holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i)
                                    && $stable(out_last_i))
    else $error("output byte changed under stall");

  // no new request while a run is still mid-way
  a_busy_mid_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_last_i |-> !in_ready_i)
    else $error("request taken in the middle of a run");

  // a release gives no bytes
  a_release_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !in_key_down_i && !out_valid_i |=> !out_valid_i)
    else $error("release produced output");

  // cursor-up press occupies the block and leads to a valid output byte
  a_up_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_key_down_i && (in_key_code_i == KeyUp) |=> !in_ready_i)
    else $error("block idle after an escape key press");

  a_up_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_key_down_i && (in_key_code_i == KeyUp) |-> ##2 out_valid_i)
    else $error("escape key press gave no byte");

endmodule

bind key_event_to_vt_utf8_bytes_core kevb_chk u_kevb_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (evt_i.valid),
  .in_ready_i    (evt_i.ready),
  .in_key_down_i (evt_i.key_down),
  .in_key_code_i (evt_i.key_code),
  .out_valid_i   (byte_o.valid),
  .out_ready_i   (byte_o.ready),
  .out_byte_i    (byte_o.out_byte),
  .out_last_i    (byte_o.last)
);
